// ===== rtl/gem_pkg.sv =====
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types, constants and helpers of the gradient edge mask block.
// ----------------------------------------------------------------------------
`default_nettype none

package gem_pkg;

    // Line store geometry
    localparam int MAX_LINE = 4096;
    localparam int LINE_AW  = $clog2(MAX_LINE);
    localparam int WID_W    = LINE_AW + 1;
    localparam int WIN      = 5;
    localparam int ROW_W    = 17;
    localparam int PIX_W    = 16;

    // Configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam logic [2:0] REG_MASK_KIND    = 3'd0;
    localparam logic [2:0] REG_BINARIZE     = 3'd1;
    localparam logic [2:0] REG_THRESHOLD    = 3'd2;
    localparam logic [2:0] REG_SCALE        = 3'd3;
    localparam logic [2:0] REG_PEAK_LEVEL   = 3'd4;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

    // Kernel codes
    localparam logic [1:0] KIND_TWO  = 2'd0;
    localparam logic [1:0] KIND_FOUR = 2'd1;
    localparam logic [1:0] KIND_SIX  = 2'd2;

    // Arithmetic widths
    localparam int G_W   = 25;
    localparam int SQ_W  = 46;
    localparam int S_W   = 47;
    localparam int Q_W   = 32;
    localparam int SC_W  = 24;
    localparam int P_W   = Q_W + SC_W;
    localparam int MAG_W = 33;
    localparam int REM_W = 36;

    // Divide by 100 through a reciprocal, valid for values below 2^23
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [32:0] LIM_100     = 33'd6553600;

    typedef struct packed {
        logic [1:0]  mask_kind;
        logic        binarize;
        logic [46:0] threshold;
        logic [23:0] scale_q16;
        logic [15:0] peak_level;
        logic [12:0] frame_width;
        logic [15:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        is_padding;
    } in_t;

    typedef struct packed {
        logic [15:0] mask_value;
        logic        last_of_frame;
    } out_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_BIN,
        RES_MAG
    } res_sel_t;

    typedef struct packed {
        logic               wr_en;
        logic [2:0]         wr_bank;
        logic [LINE_AW-1:0] wr_col;
        logic [PIX_W-1:0]   wr_pixel;
        logic               rd_en;
        logic [LINE_AW-1:0] rd_col;
        logic [2:0]         row_mod;
        logic [1:0]         kind;
        logic               grad_en;
        logic               sq_en;
        logic               sum_en;
        logic               sqrt_step;
        logic               mul_en;
        logic               rnd_en;
        logic               divm_en;
        logic               out_load;
        res_sel_t           out_sel;
        logic               out_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    // Next value of a row index modulo five
    function automatic logic [2:0] mod5_inc(input logic [2:0] v);
        return (v >= 3'd4) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    // Bank holding window row k (k = 0 is two rows above the center)
    function automatic logic [2:0] bank_of(input logic [2:0] rm, input logic [2:0] k);
        logic [3:0] t;
        t = 4'(rm) + 4'(k) + 4'd3;
        if (t >= 4'd10) begin
            t = t - 4'd10;
        end else if (t >= 4'd5) begin
            t = t - 4'd5;
        end
        return t[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gradient_edge_mask.sv =====
// ----------------------------------------------------------------------------
// gradient_edge_mask
// Gradient magnitude / binary edge mask over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per beat in raster order; is_padding beats flush
//   the tail of a frame. m_* carries zero or one mask beat per input beat,
//   lagging skip*width+skip positions (skip 2 for the four-pixel kernel).
//   Registers must be written over the APB port only while the block is
//   idle; the block does not enforce this. Steps (accept to m_valid):
//   beat with no result: no output, next beat accepted right after.
//   border position: straight to ST_FINISH with a zero result.
//   interior: 5 line-store reads, ST_GRAD, ST_SQR, ST_SUM; in magnitude
//   mode also the 32-step square root, ST_MUL, ST_RND, ST_DIVM; ST_FINISH.
//   s_ready is low while a beat is being worked on and rises with m_valid.
// Reset: counters and registers return to defaults; the line store is not
//   cleared, so no clearing pass is needed.
// Stall: one result waits in the output register; a beat may be accepted
//   meanwhile, and the next result holds until m_ready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_edge_mask (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gem_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gem_pkg::DATA_W-1:0]  pwdata,
    output logic      [gem_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire gem_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output gem_pkg::out_t                    m_data
);
    import gem_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    gem_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    gem_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/gem_ram.sv =====
// ----------------------------------------------------------------------------
// gem_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/gem_regs.sv =====
// ----------------------------------------------------------------------------
// gem_regs
// APB-style configuration registers, 64-bit data, one register per 8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module gem_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gem_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gem_pkg::DATA_W-1:0]  pwdata,
    output logic      [gem_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output gem_pkg::cfg_t                    cfg
);
    import gem_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_hit;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready;
    assign idx    = paddr[5:3];

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_hit) begin
            case (idx)
                REG_MASK_KIND:    cfg_next.mask_kind    = pwdata[1:0];
                REG_BINARIZE:     cfg_next.binarize     = pwdata[0];
                REG_THRESHOLD:    cfg_next.threshold    = pwdata[46:0];
                REG_SCALE:        cfg_next.scale_q16    = pwdata[23:0];
                REG_PEAK_LEVEL:   cfg_next.peak_level   = pwdata[15:0];
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[12:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mask_kind    <= KIND_TWO;
            cfg_reg.binarize     <= 1'b0;
            cfg_reg.threshold    <= '0;
            cfg_reg.scale_q16    <= 24'd65536;
            cfg_reg.peak_level   <= 16'd255;
            cfg_reg.frame_width  <= 13'd1920;
            cfg_reg.frame_height <= 16'd1080;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        case (idx)
            REG_MASK_KIND:    prdata = DATA_W'(cfg_reg.mask_kind);
            REG_BINARIZE:     prdata = DATA_W'(cfg_reg.binarize);
            REG_THRESHOLD:    prdata = DATA_W'(cfg_reg.threshold);
            REG_SCALE:        prdata = DATA_W'(cfg_reg.scale_q16);
            REG_PEAK_LEVEL:   prdata = DATA_W'(cfg_reg.peak_level);
            REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_reg.frame_height);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/gem_ctrl.sv =====
// ----------------------------------------------------------------------------
// gem_ctrl
// Sequencer: position counters, store/emit bookkeeping and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gem_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire gem_pkg::cfg_t cfg,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gem_pkg::in_t  s_data,
    input  wire gem_pkg::sts_t sts,
    output gem_pkg::cmd_t      cmd
);
    import gem_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQR,
        ST_SUM,
        ST_SQRT,
        ST_MUL,
        ST_RND,
        ST_DIVM,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [LINE_AW-1:0] col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [2:0]         rmod_reg, rmod_next;
    logic [ROW_W-1:0]   er_reg, er_next;
    logic [LINE_AW-1:0] ec_reg, ec_next;
    logic [2:0]         ermod_reg, ermod_next;
    logic [LINE_AW-1:0] cur_c_reg, cur_c_next;
    logic [2:0]         cur_rm_reg, cur_rm_next;
    logic               last_reg, last_next;
    res_sel_t           sel_reg, sel_next;
    logic [5:0]         cnt_reg, cnt_next;

    logic [WID_W-1:0]   w_eff;
    logic [15:0]        h_eff;
    logic [1:0]         kind;
    logic [1:0]         skip;
    logic               accept;
    logic               wrap0, wrap1, emit, border, last, ewrap;
    logic [LINE_AW-1:0] col_a;
    logic [ROW_W-1:0]   row_a;
    logic [2:0]         rmod_a;
    logic [WID_W-1:0]   col_b1;
    logic [WID_W:0]     ec_skip;
    logic [ROW_W:0]     er_skip;
    logic [WID_W-1:0]   ec1;

    // Effective frame size and kernel
    always_comb begin
        if (cfg.frame_width < 13'd5) begin
            w_eff = WID_W'(5);
        end else if (32'(cfg.frame_width) > 32'(MAX_LINE)) begin
            w_eff = WID_W'(MAX_LINE);
        end else begin
            w_eff = WID_W'(cfg.frame_width);
        end
        h_eff = (cfg.frame_height < 16'd5) ? 16'd5 : cfg.frame_height;
        kind  = (cfg.mask_kind == KIND_FOUR || cfg.mask_kind == KIND_SIX) ?
                cfg.mask_kind : KIND_TWO;
        skip  = (kind == KIND_FOUR) ? 2'd2 : 2'd1;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Store position and emit decision
    always_comb begin
        wrap0  = (WID_W'(col_reg) >= w_eff);
        col_a  = wrap0 ? '0 : col_reg;
        row_a  = wrap0 ? ROW_W'(row_reg + 1'b1) : row_reg;
        rmod_a = wrap0 ? mod5_inc(rmod_reg) : rmod_reg;
        col_b1 = WID_W'(col_a) + 1'b1;
        wrap1  = (col_b1 >= w_eff);
        emit   = !((row_a < ROW_W'(skip)) ||
                   (row_a == ROW_W'(skip) && col_a < LINE_AW'(skip)));
        er_skip = (ROW_W+1)'(er_reg) + (ROW_W+1)'(skip);
        ec_skip = (WID_W+1)'(ec_reg) + (WID_W+1)'(skip);
        border  = (er_reg < ROW_W'(skip)) || (er_skip >= (ROW_W+1)'(h_eff)) ||
                  (ec_reg < LINE_AW'(skip)) || (ec_skip >= (WID_W+1)'(w_eff));
        ec1     = WID_W'(ec_reg) + 1'b1;
        last    = (er_reg > ROW_W'(h_eff - 16'd1)) ||
                  (er_reg == ROW_W'(h_eff - 16'd1) && ec1 >= w_eff);
        ewrap   = (ec1 >= w_eff);
    end

    // Next state
    always_comb begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rmod_next   = rmod_reg;
        er_next     = er_reg;
        ec_next     = ec_reg;
        ermod_next  = ermod_reg;
        cur_c_next  = cur_c_reg;
        cur_rm_next = cur_rm_reg;
        last_next   = last_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    col_next  = wrap1 ? '0 : col_b1[LINE_AW-1:0];
                    row_next  = wrap1 ? ROW_W'(row_a + 1'b1) : row_a;
                    rmod_next = wrap1 ? mod5_inc(rmod_a) : rmod_a;
                    if (emit) begin
                        cur_c_next  = ec_reg;
                        cur_rm_next = ermod_reg;
                        last_next   = last;
                        cnt_next    = '0;
                        ec_next     = ewrap ? '0 : ec1[LINE_AW-1:0];
                        er_next     = ewrap ? ROW_W'(er_reg + 1'b1) : er_reg;
                        ermod_next  = ewrap ? mod5_inc(ermod_reg) : ermod_reg;
                        if (last) begin
                            col_next   = '0;
                            row_next   = '0;
                            rmod_next  = '0;
                            ec_next    = '0;
                            er_next    = '0;
                            ermod_next = '0;
                        end
                        if (border) begin
                            sel_next   = RES_ZERO;
                            state_next = ST_FINISH;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd5) begin
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD: state_next = ST_SQR;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM: begin
                cnt_next = '0;
                if (cfg.binarize) begin
                    sel_next   = RES_BIN;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(Q_W - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_RND;
            ST_RND:  state_next = ST_DIVM;
            ST_DIVM: begin
                sel_next   = RES_MAG;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            rmod_reg  <= '0;
            er_reg    <= '0;
            ec_reg    <= '0;
            ermod_reg <= '0;
            cnt_reg   <= '0;
            sel_reg   <= RES_ZERO;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rmod_reg  <= rmod_next;
            er_reg    <= er_next;
            ec_reg    <= ec_next;
            ermod_reg <= ermod_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
        cur_c_reg  <= cur_c_next;
        cur_rm_reg <= cur_rm_next;
        last_reg   <= last_next;
    end

    // Datapath commands
    always_comb begin
        cmd           = '0;
        cmd.wr_en     = accept;
        cmd.wr_bank   = rmod_a;
        cmd.wr_col    = col_a;
        cmd.wr_pixel  = s_data.is_padding ? '0 : s_data.pixel;
        cmd.rd_en     = (state_reg == ST_READ) && (cnt_reg < 6'd5);
        cmd.rd_col    = LINE_AW'(cur_c_reg - LINE_AW'(2) + LINE_AW'(cnt_reg));
        cmd.row_mod   = cur_rm_reg;
        cmd.kind      = kind;
        cmd.grad_en   = (state_reg == ST_GRAD);
        cmd.sq_en     = (state_reg == ST_SQR);
        cmd.sum_en    = (state_reg == ST_SUM);
        cmd.sqrt_step = (state_reg == ST_SQRT);
        cmd.mul_en    = (state_reg == ST_MUL);
        cmd.rnd_en    = (state_reg == ST_RND);
        cmd.divm_en   = (state_reg == ST_DIVM);
        cmd.out_load  = (state_reg == ST_FINISH) && sts.out_free;
        cmd.out_sel   = sel_reg;
        cmd.out_last  = last_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/gem_dp.sv =====
// ----------------------------------------------------------------------------
// gem_dp
// Datapath: line store banks, 5x5 window, gradients, bit-serial square root,
// gain and rounding, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gem_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire gem_pkg::cfg_t cfg,
    input  wire gem_pkg::cmd_t cmd,
    output gem_pkg::sts_t      sts,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gem_pkg::out_t      m_data
);
    import gem_pkg::*;

    logic [PIX_W-1:0]        rd_data [WIN];
    logic [PIX_W-1:0]        win_reg [WIN][WIN];
    logic                    col_load_reg;
    logic signed [G_W-1:0]   gx_reg, gy_reg, gx_next, gy_next;
    logic signed [G_W-1:0]   pw [WIN][WIN];
    logic [G_W-2:0]          ax, ay;
    logic [2*(G_W-1)-1:0]    ax2, ay2;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic [S_W-1:0]          s_reg, s_next;
    logic [63:0]             vsh_reg;
    logic [REM_W-1:0]        rem_reg, rem_sh, trial;
    logic [Q_W-1:0]          root_reg;
    logic [P_W-1:0]          p_reg;
    logic [MAG_W-1:0]        num_reg, mag_reg;
    logic                    big_reg;
    logic [P_W:0]            p_r2, p_r1;
    logic [MAG_W-1:0]        y100;
    logic [46:0]             prod100;
    logic                    m_valid_reg;
    out_t                    m_data_reg;
    logic [PIX_W-1:0]        res_val;

    // Line store: one bank per window row
    for (genvar b = 0; b < WIN; b++) begin : g_bank
        gem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_ram (
            .aclk  (aclk),
            .we    (cmd.wr_en && cmd.wr_bank == 3'(b)),
            .waddr (cmd.wr_col),
            .wdata (cmd.wr_pixel),
            .re    (cmd.rd_en),
            .raddr (cmd.rd_col),
            .rdata (rd_data[b])
        );
    end

    // Window: shift in one column per read beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_load_reg <= 1'b0;
        end else begin
            col_load_reg <= cmd.rd_en;
        end
        if (col_load_reg) begin
            for (int k = 0; k < WIN; k++) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    win_reg[k][j] <= win_reg[k][j+1];
                end
                win_reg[k][WIN-1] <= rd_data[bank_of(cmd.row_mod, 3'(k))];
            end
        end
    end

    // Gradients
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            for (int j = 0; j < WIN; j++) begin
                pw[k][j] = signed'(G_W'(win_reg[k][j]));
            end
        end
        case (cmd.kind)
            KIND_FOUR: begin
                gx_next = G_W'(12) * (pw[2][0] - pw[2][4]) + G_W'(74) * (pw[2][3] - pw[2][1]);
                gy_next = G_W'(12) * (pw[4][2] - pw[0][2]) + G_W'(74) * (pw[1][2] - pw[3][2]);
            end
            KIND_SIX: begin
                gx_next = ((pw[2][3] - pw[2][1]) <<< 1) + (pw[1][3] - pw[1][1]) +
                          (pw[3][3] - pw[3][1]);
                gy_next = ((pw[3][2] - pw[1][2]) <<< 1) + (pw[3][1] - pw[1][1]) +
                          (pw[3][3] - pw[1][3]);
            end
            default: begin
                gx_next = pw[2][3] - pw[2][1];
                gy_next = pw[1][2] - pw[3][2];
            end
        endcase
    end

    assign ax     = gx_reg[G_W-1] ? (G_W-1)'(-gx_reg) : gx_reg[G_W-2:0];
    assign ay     = gy_reg[G_W-1] ? (G_W-1)'(-gy_reg) : gy_reg[G_W-2:0];
    assign ax2    = ax * ax;
    assign ay2    = ay * ay;
    assign s_next = S_W'(sqx_reg) + S_W'(sqy_reg);

    // Square root step: two radicand bits per beat
    assign rem_sh = {rem_reg[REM_W-3:0], vsh_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // Rounding per kernel divisor
    assign p_r2    = (P_W+1)'(p_reg) + (P_W+1)'(1 << 24);
    assign p_r1    = (P_W+1)'(p_reg) + (P_W+1)'(1 << 23);
    assign y100    = MAG_W'(p_reg[P_W-1:24]) + MAG_W'(50);
    assign prod100 = num_reg[22:0] * RECIP_100;

    always_ff @(posedge aclk) begin
        if (cmd.grad_en) begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.sq_en) begin
            sqx_reg <= ax2[SQ_W-1:0];
            sqy_reg <= ay2[SQ_W-1:0];
        end
        if (cmd.sum_en) begin
            s_reg    <= s_next;
            vsh_reg  <= {1'b0, s_next, 16'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            vsh_reg <= {vsh_reg[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[Q_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_en) begin
            p_reg <= root_reg * cfg.scale_q16;
        end
        if (cmd.rnd_en) begin
            case (cmd.kind)
                KIND_FOUR: begin
                    num_reg <= y100;
                    big_reg <= (y100 >= LIM_100);
                end
                KIND_SIX: begin
                    num_reg <= p_r1[P_W:24];
                    big_reg <= 1'b0;
                end
                default: begin
                    num_reg <= MAG_W'(p_r2[P_W:25]);
                    big_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.divm_en) begin
            if (cmd.kind == KIND_FOUR) begin
                mag_reg <= big_reg ? MAG_W'(1 << 16) : MAG_W'(prod100[46:RECIP_SHIFT]);
            end else begin
                mag_reg <= num_reg;
            end
        end
    end

    // Result select and clamp
    always_comb begin
        case (cmd.out_sel)
            RES_BIN: res_val = (s_reg > cfg.threshold) ? cfg.peak_level : '0;
            RES_MAG: res_val = (mag_reg > MAG_W'(cfg.peak_level)) ?
                               cfg.peak_level : mag_reg[PIX_W-1:0];
            default: res_val = '0;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.mask_value    <= res_val;
            m_data_reg.last_of_frame <= cmd.out_last;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gem_check.sv =====
// ----------------------------------------------------------------------------
// gem_check
// Port-level checks of the gradient edge mask, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gem_check (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       pready,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire gem_pkg::out_t              m_data
);

    // A stalled result beat stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("m_data changed while stalled");

    // Config port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

    // A new result is loaded only after the input side has been closed
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while input side was open");

endmodule

bind gradient_edge_mask gem_check u_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .pready  (pready),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Edge mask bench: small frames under every kernel and mode, with random
// pixels, flush beats and random idle on both channels. Each accepted input
// beat is run through a local line-store predictor, and the mask beats that
// come out are checked in order against the predicted ones.
// ----------------------------------------------------------------------------
module tb;
    import gem_pkg::*;

    localparam int STORE_DEPTH = 5 * MAX_LINE;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    gradient_edge_mask dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Register shadow used by the predictor
    logic [1:0]  cfg_kind  = 2'd0;
    logic        cfg_bin   = 1'b0;
    logic [46:0] cfg_thr   = '0;
    logic [23:0] cfg_scale = 24'd65536;
    logic [15:0] cfg_pmax  = 16'd255;
    logic [12:0] cfg_w     = 13'd1920;
    logic [15:0] cfg_h     = 16'd1080;

    // Predictor state
    logic [15:0] pix_store [STORE_DEPTH];
    longint unsigned col_pos = 0;
    longint unsigned row_pos = 0;
    longint unsigned emit_pos = 0;

    in_t  pending_pixels[$];
    out_t mask_expected[$];
    int   errors = 0;
    bit   idle_on = 1'b1;
    int   hold_tokens = 0;
    int   hold_taken = 0;
    int   hold_left = 0;

    function automatic longint unsigned width_used();
        if (cfg_w < 5) return 5;
        if (cfg_w > MAX_LINE) return MAX_LINE;
        return cfg_w;
    endfunction

    function automatic longint unsigned height_used();
        return (cfg_h < 5) ? 5 : cfg_h;
    endfunction

    function automatic longint unsigned skip_rows();
        return (cfg_kind == KIND_FOUR) ? 2 : 1;
    endfunction

    function automatic longint pix_at(longint unsigned r, longint unsigned c);
        return longint'(pix_store[(r % 5) * MAX_LINE + (c % MAX_LINE)]);
    endfunction

    // floor(sqrt(v)), bit by bit from the top
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned t;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            t = res | (64'd1 << b);
            if (t * t <= v) res = t;
        end
        return res;
    endfunction

    function automatic logic [15:0] edge_strength(longint unsigned r, longint unsigned c,
                                                  longint unsigned w, longint unsigned h);
        logic [1:0] kind;
        longint unsigned s, sq, q, d, mag;
        longint gx, gy, tp, bt, lf, rt;
        kind = (cfg_kind == KIND_FOUR || cfg_kind == KIND_SIX) ? cfg_kind : KIND_TWO;
        s = (kind == KIND_FOUR) ? 2 : 1;
        if (r < s || r + s >= h || c < s || c + s >= w) return 16'd0;
        tp = pix_at(r - 1, c);
        bt = pix_at(r + 1, c);
        lf = pix_at(r, c - 1);
        rt = pix_at(r, c + 1);
        if (kind == KIND_TWO) begin
            gx = rt - lf;
            gy = tp - bt;
            d = 2;
        end else if (kind == KIND_FOUR) begin
            gx = 12 * (pix_at(r, c - 2) - pix_at(r, c + 2)) + 74 * (rt - lf);
            gy = 12 * (pix_at(r + 2, c) - pix_at(r - 2, c)) + 74 * (tp - bt);
            d = 100;
        end else begin
            gx = 2 * (rt - lf) + (pix_at(r - 1, c + 1) - pix_at(r - 1, c - 1))
                 + (pix_at(r + 1, c + 1) - pix_at(r + 1, c - 1));
            gy = 2 * (bt - tp) + (pix_at(r + 1, c - 1) - pix_at(r - 1, c - 1))
                 + (pix_at(r + 1, c + 1) - pix_at(r - 1, c + 1));
            d = 1;
        end
        sq = longint'(gx * gx) + longint'(gy * gy);
        if (cfg_bin) return (sq > cfg_thr) ? cfg_pmax : 16'd0;
        q = floor_root(sq << 16);
        d = d << 24;
        mag = (q * cfg_scale + d / 2) / d;
        return (mag > cfg_pmax) ? cfg_pmax : mag[15:0];
    endfunction

    // Store one accepted beat and queue the mask beat it releases, if any
    task automatic predict_mask(input in_t beat);
        longint unsigned w, h, lag, pos, m;
        out_t res;
        w = width_used();
        h = height_used();
        lag = skip_rows() * w + skip_rows();
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        pix_store[(row_pos % 5) * MAX_LINE + col_pos] = beat.is_padding ? 16'd0 : beat.pixel;
        pos = row_pos * w + col_pos;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (pos >= lag) begin
            m = emit_pos;
            res.mask_value = edge_strength(m / w, m % w, w, h);
            res.last_of_frame = (m + 1 >= w * h);
            if (res.last_of_frame) begin
                col_pos = 0;
                row_pos = 0;
                emit_pos = 0;
            end else begin
                emit_pos = m + 1;
            end
            mask_expected.push_back(res);
        end
    endtask

    // Sender: feeds pending pixels, random idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_pixels.size() > 0 && !(idle_on && $urandom_range(99) < 13)) begin
                s_valid <= 1'b1;
                s_data <= pending_pixels.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random idle plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_taken != hold_tokens) begin
            hold_taken <= hold_tokens;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 13);
        end
    end

    // Input beats into the predictor, output beats against it
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_mask(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (mask_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected mask beat %h", $time, m_data);
            end else begin
                out_t want;
                want = mask_expected.pop_front();
                if (m_data.mask_value !== want.mask_value) begin
                    errors++;
                    $display("%0t: mask_value expected %0d actual %0d",
                             $time, want.mask_value, m_data.mask_value);
                end
                if (m_data.last_of_frame !== want.last_of_frame) begin
                    errors++;
                    $display("%0t: last_of_frame expected %0b actual %0b",
                             $time, want.last_of_frame, m_data.last_of_frame);
                end
            end
        end
    end

    // APB write: setup cycle, access cycle
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MASK_KIND:    cfg_kind = val[1:0];
            REG_BINARIZE:     cfg_bin = val[0];
            REG_THRESHOLD:    cfg_thr = val[46:0];
            REG_SCALE:        cfg_scale = val[23:0];
            REG_PEAK_LEVEL:   cfg_pmax = val[15:0];
            REG_FRAME_WIDTH:  cfg_w = val[12:0];
            REG_FRAME_HEIGHT: cfg_h = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [1:0] kind, input logic bin, input logic [46:0] thr,
                           input logic [23:0] scale, input logic [15:0] pmax,
                           input logic [12:0] w, input logic [15:0] h);
        reg_write(REG_MASK_KIND, 64'(kind));
        reg_write(REG_BINARIZE, 64'(bin));
        reg_write(REG_THRESHOLD, 64'(thr));
        reg_write(REG_SCALE, 64'(scale));
        reg_write(REG_PEAK_LEVEL, 64'(pmax));
        reg_write(REG_FRAME_WIDTH, 64'(w));
        reg_write(REG_FRAME_HEIGHT, 64'(h));
    endtask

    // One whole frame plus flush beats, then drain.
    // style: 0 random band, 1 checkerboard of extremes
    task automatic send_frame(input int style, output int sent);
        longint unsigned w, h, n;
        int spread, base;
        in_t b;
        w = width_used();
        h = height_used();
        n = w * h + skip_rows() * w + skip_rows();
        case ($urandom_range(2))
            0: spread = 3;
            1: spread = 200;
            default: spread = 65535;
        endcase
        base = $urandom_range(65535 - spread);
        for (longint unsigned i = 0; i < n; i++) begin
            b.pixel = (style == 1) ? (((i % w + i / w) % 2) ? 16'hFFFF : 16'h0000)
                                   : 16'(base + $urandom_range(spread));
            b.is_padding = (i >= w * h) || ($urandom_range(19) == 0);
            if (b.is_padding && $urandom_range(1)) b.pixel = 16'($urandom);
            pending_pixels.push_back(b);
        end
        sent = n;
        while (pending_pixels.size() > 0 || s_valid || mask_expected.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        int sent, total;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: each kernel on a 5x5 checkerboard in magnitude mode, then binary
        set_all(KIND_TWO, 1'b0, 47'd0, 24'd65536, 16'd255, 13'd5, 16'd5);
        send_frame(1, sent);
        reg_write(REG_MASK_KIND, 64'(KIND_FOUR));
        reg_write(REG_PEAK_LEVEL, 64'(16'hFFFF));
        send_frame(1, sent);
        reg_write(REG_MASK_KIND, 64'(KIND_SIX));
        reg_write(REG_SCALE, 64'(24'hFFFFFF));
        send_frame(1, sent);
        // unused kernel code, width and height below range, binary at max threshold
        reg_write(REG_FRAME_HEIGHT, 64'(16'hFFFF));
        set_all(2'd3, 1'b1, 47'h7FFF_FFFF_FFFF, 24'd0, 16'd255, 13'd0, 16'd0);
        send_frame(1, sent);
        reg_write(REG_THRESHOLD, 64'(47'd0));
        send_frame(0, sent);

        // Random frames; the first one with a long receiver hold-off
        total = 0;
        while (total < 270) begin
            logic [46:0] thr;
            thr = $urandom_range(3) == 0 ? {15'($urandom), 32'($urandom)}
                                          : 47'($urandom_range(1 << 20));
            set_all(2'($urandom_range(3)), 1'($urandom_range(1)), thr,
                    ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(200000)),
                    16'($urandom_range(255, 65535)),
                    13'($urandom_range(5, 10)), 16'($urandom_range(5, 7)));
            if (total == 0) hold_tokens++;
            idle_on = (total < 90 || total > 190);
            send_frame($urandom_range(9) == 0, sent);
            total += sent;
        end
        idle_on = 1'b1;

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
